### sv/rcsl_pkg.sv
// rcsl_pkg: shared widths, constants, register indexes and types of the
// remote-control stick link supervisor. No dependencies.
package rcsl_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int STICK_BITS_DEF = 12;

  localparam int LIM_W   = 6;
  localparam int DZ_W    = 10;
  localparam int TO_W    = 24;
  localparam int PER_W   = 20;
  localparam int CFG_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int KEY_W   = 4;
  localparam int SW_W    = 8;
  localparam int CNT_W   = 8;
  localparam int ERR_W   = 18;
  localparam int ANGLE_W = 35;
  localparam int HEAD_W  = 36;
  localparam int DT_W    = 17;

  localparam int OUT_BITS = 2 * ERR_W + ANGLE_W + CNT_W + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam int BAND_COUNTS = 200;
  localparam int MAX_DT      = 100000;
  localparam logic [DT_W-1:0] FIRST_DT = DT_W'(10000);

  localparam logic signed [HEAD_W-1:0] HALF_TURN = HEAD_W'(64'sd12000000000);
  localparam logic signed [HEAD_W-1:0] FULL_TURN = HEAD_W'(64'sd24000000000);

  localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(255);
  localparam logic [SW_W-1:0]  SW_UNKNOWN = SW_W'(255);
  localparam logic [SW_W-1:0]  SW_HIGH    = SW_W'(1);
  localparam logic [SW_W-1:0]  SW_LOW     = SW_W'(0);

  localparam logic [LIM_W-1:0] FWD_LIMIT_RST   = LIM_W'(6);
  localparam logic [LIM_W-1:0] LAT_LIMIT_RST   = LIM_W'(6);
  localparam logic [DZ_W-1:0]  DEADZONE_RST    = DZ_W'(80);
  localparam logic [TO_W-1:0]  FRAME_TO_RST    = TO_W'(200000);
  localparam logic [TO_W-1:0]  IDLE_TO_RST     = TO_W'(2000000);
  localparam logic [PER_W-1:0] COUNT_PER_RST   = PER_W'(50000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FWD_LIMIT     = 3'd0,
    CFG_LAT_LIMIT     = 3'd1,
    CFG_DEADZONE      = 3'd2,
    CFG_FRAME_TIMEOUT = 3'd3,
    CFG_IDLE_TIMEOUT  = 3'd4,
    CFG_COUNT_PERIOD  = 3'd5
  } cfg_reg_t;

  // link state seen by one tick, after that tick
  typedef struct packed {
    logic             disc;
    logic [DT_W-1:0]  dt;
    logic             lost;
    logic [CNT_W-1:0] cnt;
    logic             fin;
  } link_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

### sv/rc_stick_link_supervisor_top.sv
// Stick link supervisor top level: stream ports, configuration registers,
// stick shaping and the five-register pipeline. Depends on rcsl_pkg,
// rcsl_link and rcsl_heading.
// A tick moves through the s1, s2, s3, s4 and output registers in order.
// One tick per cycle unless the output stalls; the heading is a single register.
// Back-pressure ripples stage by stage, so empty stages keep accepting.
// Reset (synchronous): pipeline empties, link state, heading and finish latch
// clear, configuration registers return to their defaults.
module rc_stick_link_supervisor_top #(
  parameter int TIME_BITS  = rcsl_pkg::TIME_BITS_DEF,
  parameter int STICK_BITS = rcsl_pkg::STICK_BITS_DEF,
  localparam int IN_BITS   = TIME_BITS + 3 * STICK_BITS + 14,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rcsl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcsl_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // now_us, frame_new, stick_lat, stick_fwd, stick_yaw, key_mask, switch_pos, armed
  input  logic [IN_W-1:0]                s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // err_fwd, err_lat, angle_out, beacon_lost, lost_ticks, finished
  output logic [rcsl_pkg::OUT_W-1:0]     m_axis_tdata
);
  import rcsl_pkg::*;

  localparam int OFS_FNEW = TIME_BITS;
  localparam int OFS_LAT  = OFS_FNEW + 1;
  localparam int OFS_FWD  = OFS_LAT + STICK_BITS;
  localparam int OFS_YAW  = OFS_FWD + STICK_BITS;
  localparam int OFS_KEY  = OFS_YAW + STICK_BITS;
  localparam int OFS_SW   = OFS_KEY + KEY_W;
  localparam int OFS_ARM  = OFS_SW + SW_W;

  localparam int AX_LAT = 0;
  localparam int AX_FWD = 1;
  localparam int AX_YAW = 2;

  localparam int DW = ((STICK_BITS > DZ_W) ? STICK_BITS : DZ_W) + 2;
  localparam int EW = ((STICK_BITS + LIM_W + 1) > ERR_W) ? (STICK_BITS + LIM_W + 1) : ERR_W;
  localparam logic signed [DW-1:0] BAND_X = DW'(BAND_COUNTS);

  // configuration
  logic [LIM_W-1:0] fwd_limit, lat_limit;
  logic [DZ_W-1:0]  deadzone;
  logic [TO_W-1:0]  frame_timeout, idle_timeout;
  logic [PER_W-1:0] count_period;

  // handshake chain
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // stage 1: captured tick
  logic [IN_BITS-1:0] s1_data;
  logic signed [STICK_BITS-1:0] raw [3];
  logic signed [STICK_BITS-1:0] axis_d [3];
  logic [2:0] axis_band;

  logic signed [EW-1:0] fwd_x, lat_x, fwd_lim_x, lat_lim_x, fwd_prod, lat_prod, lat_neg;
  logic fwd_on, lat_on, yaw_on, act;

  // stage 2
  logic [TIME_BITS-1:0]         s2_now;
  logic                         s2_fnew, s2_active, s2_armed;
  logic [SW_W-1:0]              s2_sw;
  logic signed [STICK_BITS-1:0] s2_dyaw;
  logic [ERR_W-1:0]             s2_efwd, s2_elat;
  link_status_t                 link_st;

  // stage 3
  link_status_t                 s3_st;
  logic signed [STICK_BITS-1:0] s3_dyaw;
  logic [ERR_W-1:0]             s3_efwd, s3_elat;

  // stage 4 and output
  logic [ERR_W-1:0] s4_efwd, s4_elat, o_efwd, o_elat;
  logic             s4_lost, s4_fin, o_lost, o_fin;
  logic [CNT_W-1:0] s4_cnt, o_cnt;
  logic [ANGLE_W-1:0] angle;

  assign rdy_out = !m_axis_tvalid || m_axis_tready;
  assign rdy4    = !s4_valid || rdy_out;
  assign rdy3    = !s3_valid || rdy4;
  assign rdy2    = !s2_valid || rdy3;
  assign rdy1    = !s1_valid || rdy2;
  assign s_axis_tready = rdy1;

  // stick dead zone and residue band per axis
  assign raw[AX_LAT] = s1_data[OFS_LAT +: STICK_BITS];
  assign raw[AX_FWD] = s1_data[OFS_FWD +: STICK_BITS];
  assign raw[AX_YAW] = s1_data[OFS_YAW +: STICK_BITS];

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [DW-1:0] raw_x, dz_x, d_x;
    assign raw_x = DW'(raw[i]);
    assign dz_x  = $signed(DW'(deadzone));
    always_comb begin
      if (raw_x > dz_x) begin
        d_x = raw_x - dz_x;
      end else if (raw_x < -dz_x) begin
        d_x = raw_x + dz_x;
      end else begin
        d_x = '0;
      end
    end
    assign axis_d[i]    = d_x[STICK_BITS-1:0];
    assign axis_band[i] = (d_x > BAND_X) || (d_x < -BAND_X);
  end

  assign fwd_on = axis_band[AX_FWD] && (fwd_limit != '0);
  assign lat_on = axis_band[AX_LAT] && (lat_limit != '0);
  assign yaw_on = axis_band[AX_YAW];
  assign act    = fwd_on || lat_on || yaw_on || (s1_data[OFS_KEY +: KEY_W] != '0);

  assign fwd_x     = EW'(axis_d[AX_FWD]);
  assign lat_x     = EW'(axis_d[AX_LAT]);
  assign fwd_lim_x = $signed(EW'(fwd_limit));
  assign lat_lim_x = $signed(EW'(lat_limit));
  assign fwd_prod  = fwd_x * fwd_lim_x;
  assign lat_prod  = lat_x * lat_lim_x;
  assign lat_neg   = -lat_prod;

  rcsl_link #(
    .TIME_BITS(TIME_BITS)
  ) u_link (
    .clk           (clk),
    .rst           (rst),
    .advance       (s2_valid && rdy3),
    .now           (s2_now),
    .frame_new     (s2_fnew),
    .active        (s2_active),
    .sw            (s2_sw),
    .armed         (s2_armed),
    .frame_timeout (frame_timeout),
    .idle_timeout  (idle_timeout),
    .count_period  (count_period),
    .status        (link_st)
  );

  rcsl_heading #(
    .STICK_BITS(STICK_BITS)
  ) u_heading (
    .clk        (clk),
    .rst        (rst),
    .load_delta (rdy4),
    .d_yaw      (s3_dyaw),
    .dt         (s3_st.dt),
    .hold       (s3_st.disc),
    .load_head  (s4_valid && rdy_out),
    .angle      (angle)
  );

  // control: valid bits and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      s4_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      fwd_limit     <= FWD_LIMIT_RST;
      lat_limit     <= LAT_LIMIT_RST;
      deadzone      <= DEADZONE_RST;
      frame_timeout <= FRAME_TO_RST;
      idle_timeout  <= IDLE_TO_RST;
      count_period  <= COUNT_PER_RST;
    end else begin
      if (rdy1)    s1_valid      <= s_axis_tvalid;
      if (rdy2)    s2_valid      <= s1_valid;
      if (rdy3)    s3_valid      <= s2_valid;
      if (rdy4)    s4_valid      <= s3_valid;
      if (rdy_out) m_axis_tvalid <= s4_valid;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_FWD_LIMIT:     fwd_limit     <= cfg_data[LIM_W-1:0];
          CFG_LAT_LIMIT:     lat_limit     <= cfg_data[LIM_W-1:0];
          CFG_DEADZONE:      deadzone      <= cfg_data[DZ_W-1:0];
          CFG_FRAME_TIMEOUT: frame_timeout <= cfg_data[TO_W-1:0];
          CFG_IDLE_TIMEOUT:  idle_timeout  <= cfg_data[TO_W-1:0];
          CFG_COUNT_PERIOD:  count_period  <= cfg_data[PER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_data <= s_axis_tdata[IN_BITS-1:0];
    end
    if (rdy2) begin
      s2_now    <= s1_data[TIME_BITS-1:0];
      s2_fnew   <= s1_data[OFS_FNEW];
      s2_active <= act;
      s2_sw     <= s1_data[OFS_SW +: SW_W];
      s2_armed  <= s1_data[OFS_ARM];
      s2_dyaw   <= yaw_on ? axis_d[AX_YAW] : '0;
      s2_efwd   <= fwd_on ? fwd_prod[ERR_W-1:0] : '0;
      s2_elat   <= lat_on ? lat_neg[ERR_W-1:0] : '0;
    end
    if (rdy3) begin
      s3_st   <= link_st;
      s3_dyaw <= s2_dyaw;
      s3_efwd <= s2_efwd;
      s3_elat <= s2_elat;
    end
    if (rdy4) begin
      s4_efwd <= s3_st.disc ? '0 : s3_efwd;
      s4_elat <= s3_st.disc ? '0 : s3_elat;
      s4_lost <= s3_st.lost;
      s4_cnt  <= s3_st.cnt;
      s4_fin  <= s3_st.fin;
    end
    if (rdy_out) begin
      o_efwd <= s4_efwd;
      o_elat <= s4_elat;
      o_lost <= s4_lost;
      o_cnt  <= s4_cnt;
      o_fin  <= s4_fin;
    end
  end

  assign m_axis_tdata = {(OUT_W - OUT_BITS)'(0), o_fin, o_cnt, o_lost, angle, o_elat, o_efwd};

  a_stall_only_from_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output side free");

endmodule

### sv/rcsl_link.sv
// rcsl_link: beacon/link supervision, lost counter, finish latch and tick
// interval. Holds the timestamp state. Depends on rcsl_pkg.
module rcsl_link #(
  parameter int TIME_BITS = rcsl_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [TIME_BITS-1:0]       now,
  input  logic                       frame_new,
  input  logic                       active,
  input  logic [rcsl_pkg::SW_W-1:0]  sw,
  input  logic                       armed,
  input  logic [rcsl_pkg::TO_W-1:0]  frame_timeout,
  input  logic [rcsl_pkg::TO_W-1:0]  idle_timeout,
  input  logic [rcsl_pkg::PER_W-1:0] count_period,
  output rcsl_pkg::link_status_t     status
);
  import rcsl_pkg::*;

  logic [TIME_BITS-1:0] last_frame, last_active, last_count, last_tick;
  logic [TIME_BITS-1:0] last_frame_next, last_active_next, last_count_next, last_tick_next;
  logic                 lost, lost_next;
  logic [CNT_W-1:0]     cnt, cnt_next;
  logic                 fin, fin_next;
  logic [SW_W-1:0]      prev_sw;

  logic [TIME_BITS-1:0] age_frame, age_active, age_tick, age_count, count_base;
  logic [CNT_W-1:0]     cnt_base;
  logic                 frame_to, idle_to, disc;
  logic [DT_W-1:0]      dt;

  assign age_frame  = now - last_frame;
  assign age_active = now - last_active;
  assign age_tick   = now - last_tick;
  assign frame_to   = age_frame > TIME_BITS'(frame_timeout);
  assign idle_to    = age_active > TIME_BITS'(idle_timeout);

  // on entry to the lost state the period restarts from now
  assign count_base = lost ? last_count : now;
  assign cnt_base   = lost ? cnt : '0;
  assign age_count  = now - count_base;

  always_comb begin
    last_frame_next  = last_frame;
    last_active_next = last_active;
    last_count_next  = last_count;
    last_tick_next   = last_tick;
    lost_next        = lost;
    cnt_next         = cnt;
    disc             = 1'b0;
    fin_next         = fin | ((prev_sw == SW_HIGH) && (sw == SW_LOW) && armed);

    if (frame_new) begin
      last_frame_next = now;
      if (active) begin
        last_active_next = now;
        if (lost) begin
          lost_next = 1'b0;
          cnt_next  = '0;
        end
      end else if (idle_to) begin
        lost_next = 1'b1;
        cnt_next  = sat_inc(cnt_base);
      end
    end else if (frame_to) begin
      disc      = 1'b1;
      lost_next = 1'b1;
      if (age_count >= TIME_BITS'(count_period)) begin
        last_count_next = now;
        cnt_next        = sat_inc(cnt_base);
      end else begin
        last_count_next = count_base;
        cnt_next        = cnt_base;
      end
    end

    if (last_tick != '0 && age_tick != '0 && age_tick <= TIME_BITS'(MAX_DT)) begin
      dt = age_tick[DT_W-1:0];
    end else begin
      dt = FIRST_DT;
    end
    if (!disc) begin
      last_tick_next = now;
    end
  end

  assign status.disc = disc;
  assign status.dt   = dt;
  assign status.lost = lost_next;
  assign status.cnt  = cnt_next;
  assign status.fin  = fin_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame  <= '0;
      last_active <= '0;
      last_count  <= '0;
      last_tick   <= '0;
      lost        <= 1'b0;
      cnt         <= '0;
      fin         <= 1'b0;
      prev_sw     <= SW_UNKNOWN;
    end else if (advance) begin
      last_frame  <= last_frame_next;
      last_active <= last_active_next;
      last_count  <= last_count_next;
      last_tick   <= last_tick_next;
      lost        <= lost_next;
      cnt         <= cnt_next;
      fin         <= fin_next;
      prev_sw     <= sw;
    end
  end

  a_found_clears_count: assert property (@(posedge clk) disable iff (rst)
    !lost |-> cnt == '0)
    else $error("lost counter nonzero while beacon found");

  a_finish_sticky: assert property (@(posedge clk) disable iff (rst)
    fin |=> fin)
    else $error("finish latch dropped");

  a_dt_range: assert property (@(posedge clk) disable iff (rst)
    dt != '0 && dt <= DT_W'(MAX_DT))
    else $error("tick interval out of range");

endmodule

### sv/rcsl_heading.sv
// rcsl_heading: yaw integration into the target heading, with wrap at half
// a turn. One multiply stage, one accumulate stage. Depends on rcsl_pkg.
module rcsl_heading #(
  parameter int STICK_BITS = rcsl_pkg::STICK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load_delta,
  input  logic signed [STICK_BITS-1:0]  d_yaw,
  input  logic [rcsl_pkg::DT_W-1:0]     dt,
  input  logic                          hold,
  input  logic                          load_head,
  output logic [rcsl_pkg::ANGLE_W-1:0]  angle
);
  import rcsl_pkg::*;

  localparam int PW = STICK_BITS + DT_W + 1;

  logic signed [PW-1:0]     yaw_x, dt_x, prod;
  logic signed [HEAD_W-1:0] delta, heading, diff, heading_next;

  assign yaw_x = PW'(d_yaw);
  assign dt_x  = $signed(PW'(dt));
  assign prod  = yaw_x * dt_x;

  assign diff = heading - delta;

  always_comb begin
    if (diff > HALF_TURN) begin
      heading_next = diff - FULL_TURN;
    end else if (diff < -HALF_TURN) begin
      heading_next = diff + FULL_TURN;
    end else begin
      heading_next = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (load_delta) begin
      delta <= hold ? '0 : HEAD_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heading <= '0;
    end else if (load_head) begin
      heading <= heading_next;
    end
  end

  // heading holds the angle of the result currently in the output register
  assign angle = heading[ANGLE_W-1:0];

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    heading <= HALF_TURN && heading >= -HALF_TURN)
    else $error("heading outside half-turn range");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the stick link supervisor. Drives ticks on the
// input stream, predicts every result in a model of its own and checks the output stream.
// Depends on rcsl_pkg and rc_stick_link_supervisor_top.
module tb_top;
  import rcsl_pkg::*;

  typedef struct packed {
    logic               armed;
    logic [SW_W-1:0]    switch_pos;
    logic [KEY_W-1:0]   key_mask;
    logic signed [11:0] stick_yaw;
    logic signed [11:0] stick_fwd;
    logic signed [11:0] stick_lat;
    logic               frame_new;
    logic [47:0]        now_us;
  } tick_t;

  typedef struct packed {
    logic                      finished;
    logic [CNT_W-1:0]          lost_ticks;
    logic                      beacon_lost;
    logic signed [ANGLE_W-1:0] angle_out;
    logic signed [ERR_W-1:0]   err_lat;
    logic signed [ERR_W-1:0]   err_fwd;
  } result_t;

  localparam int TICK_W = $bits(tick_t);
  localparam int IN_W   = ((TICK_W + 7) / 8) * 8;
  localparam int RES_W  = $bits(result_t);
  localparam longint HALF_SPAN = HALF_TURN;
  localparam longint FULL_SPAN = FULL_TURN;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;

  rc_stick_link_supervisor_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  // configuration copy
  int          lim_fwd = int'(FWD_LIMIT_RST);
  int          lim_lat = int'(LAT_LIMIT_RST);
  int          dz_counts = int'(DEADZONE_RST);
  logic [23:0] frame_to = FRAME_TO_RST;
  logic [23:0] idle_to = IDLE_TO_RST;
  logic [19:0] count_per = COUNT_PER_RST;

  // link and heading state
  logic [47:0]      frame_seen_at = '0;
  logic [47:0]      active_seen_at = '0;
  logic [47:0]      count_mark = '0;
  logic [47:0]      tick_seen_at = '0;
  logic             beacon_lost = 1'b0;
  logic [CNT_W-1:0] lost_count = '0;
  longint           aim_angle = 0;
  logic             finish_latched = 1'b0;
  logic [SW_W-1:0]  sw_prev = SW_UNKNOWN;

  tick_t   tick_queue[$];
  result_t due_results[$];
  int      queued_total = 0;
  int      taken_total = 0;
  int      mismatches = 0;
  logic [47:0] gen_now = '0;

  bit send_gaps_on = 1'b1;
  bit recv_stalls_on = 1'b1;
  int hold_reqs = 0;
  int hold_served = 0;
  int hold_left = 0;
  int send_gap = 0;
  int stall_left = 0;

  task automatic report_mismatch(string field, longint got, longint want);
    mismatches++;
    $display("%0t: %s got %0d expected %0d", $time, field, got, want);
  endtask

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int shape_stick(logic signed [11:0] raw);
    int v;
    v = int'(raw);
    if (v > dz_counts) return v - dz_counts;
    if (v < -dz_counts) return v + dz_counts;
    return 0;
  endfunction

  // one tick of the supervisor: link state, gated errors and heading
  task automatic advance_link(input tick_t t);
    int          dl, df, dy;
    bit          fwd_on, lat_on, yaw_on, cut_off;
    logic [47:0] step_us;
    result_t     r;
    dl = shape_stick(t.stick_lat);
    df = shape_stick(t.stick_fwd);
    dy = shape_stick(t.stick_yaw);
    fwd_on = lim_fwd != 0 && (df > BAND_COUNTS || df < -BAND_COUNTS);
    lat_on = lim_lat != 0 && (dl > BAND_COUNTS || dl < -BAND_COUNTS);
    yaw_on = dy > BAND_COUNTS || dy < -BAND_COUNTS;
    cut_off = 1'b0;

    if (sw_prev != SW_UNKNOWN && t.armed && sw_prev == SW_HIGH && t.switch_pos == SW_LOW)
      finish_latched = 1'b1;
    sw_prev = t.switch_pos;

    if (t.frame_new) begin
      frame_seen_at = t.now_us;
      if (fwd_on || lat_on || yaw_on || t.key_mask != '0) begin
        active_seen_at = t.now_us;
        if (beacon_lost) begin
          beacon_lost = 1'b0;
          lost_count = '0;
        end
      end else if (t.now_us - active_seen_at > 48'(idle_to)) begin
        if (!beacon_lost) begin
          beacon_lost = 1'b1;
          lost_count = '0;
        end
        if (lost_count != CNT_MAX) lost_count++;
      end
    end else if (t.now_us - frame_seen_at > 48'(frame_to)) begin
      cut_off = 1'b1;
      if (!beacon_lost) begin
        beacon_lost = 1'b1;
        lost_count = '0;
        count_mark = t.now_us;
      end
      if (t.now_us - count_mark >= 48'(count_per)) begin
        count_mark = t.now_us;
        if (lost_count != CNT_MAX) lost_count++;
      end
    end

    r = '0;
    if (!cut_off) begin
      step_us = 48'(FIRST_DT);
      if (tick_seen_at != '0) begin
        step_us = t.now_us - tick_seen_at;
        if (step_us == '0 || step_us > 48'(MAX_DT)) step_us = 48'(FIRST_DT);
      end
      tick_seen_at = t.now_us;
      if (fwd_on) r.err_fwd = ERR_W'(df * lim_fwd);
      if (lat_on) r.err_lat = ERR_W'(-(dl * lim_lat));
      if (yaw_on) aim_angle -= longint'(dy) * longint'(step_us);
      if (aim_angle > HALF_SPAN) aim_angle -= FULL_SPAN;
      if (aim_angle < -HALF_SPAN) aim_angle += FULL_SPAN;
    end
    r.angle_out   = aim_angle[ANGLE_W-1:0];
    r.beacon_lost = beacon_lost;
    r.lost_ticks  = lost_count;
    r.finished    = finish_latched;
    due_results.push_back(r);
  endtask

  // input side: a transfer is predicted at the edge it completes
  always @(posedge clk) begin : drive
    tick_t on_wire;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        advance_link(on_wire);
        taken_total++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          on_wire = tick_queue.pop_front();
          s_axis_tdata <= {{(IN_W - TICK_W){1'b0}}, on_wire};
          s_axis_tvalid <= 1'b1;
          send_gap = send_gaps_on ? pick_pause() : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin : watch
    result_t seen, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'(m_axis_tdata[RES_W-1:0]);
        if (due_results.size() == 0) begin
          report_mismatch("result with none due", 0, 0);
        end else begin
          want = due_results.pop_front();
          if (seen.err_fwd !== want.err_fwd)
            report_mismatch("err_fwd", seen.err_fwd, want.err_fwd);
          if (seen.err_lat !== want.err_lat)
            report_mismatch("err_lat", seen.err_lat, want.err_lat);
          if (seen.angle_out !== want.angle_out)
            report_mismatch("angle_out", seen.angle_out, want.angle_out);
          if (seen.beacon_lost !== want.beacon_lost)
            report_mismatch("beacon_lost", seen.beacon_lost, want.beacon_lost);
          if (seen.lost_ticks !== want.lost_ticks)
            report_mismatch("lost_ticks", seen.lost_ticks, want.lost_ticks);
          if (seen.finished !== want.finished)
            report_mismatch("finished", seen.finished, want.finished);
        end
      end
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left = 120;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = recv_stalls_on ? pick_pause() : 0;
      end
    end
  end

  task automatic queue_tick(input tick_t t);
    tick_queue.push_back(t);
    queued_total++;
  endtask

  task automatic direct_tick(logic [47:0] now, bit fnew, int lat, int fwd, int yaw,
                             logic [3:0] keys, logic [7:0] sw, bit arm);
    tick_t t;
    t.now_us = now;
    t.frame_new = fnew;
    t.stick_lat = 12'(lat);
    t.stick_fwd = 12'(fwd);
    t.stick_yaw = 12'(yaw);
    t.key_mask = keys;
    t.switch_pos = sw;
    t.armed = arm;
    queue_tick(t);
  endtask

  // quiet sticks stay within the residue band past the dead zone
  function automatic logic [11:0] pick_stick(bit quiet);
    int rim, m, r;
    rim = dz_counts + BAND_COUNTS;
    if (rim > 2047) rim = 2047;
    r = $urandom_range(0, 99);
    if (quiet) m = $urandom_range(0, rim);
    else if (r < 45) return 12'($urandom);
    else if (r < 60) return $urandom_range(0, 1) ? 12'h7FF : 12'h800;
    else if (r < 80) m = rim + $urandom_range(0, 1);
    else m = $urandom_range(rim, 2047);
    if (m > 2047) m = 2047;
    return $urandom_range(0, 1) ? 12'(m) : 12'(-m);
  endfunction

  function automatic logic [7:0] pick_switch();
    if ($urandom_range(0, 99) >= 70) return 8'($urandom);
    case ($urandom_range(0, 2))
      0: return SW_LOW;
      1: return SW_HIGH;
      default: return SW_UNKNOWN;
    endcase
  endfunction

  task automatic random_ticks(int n, int p_frame, int p_quiet, int max_step);
    tick_t t;
    int    r;
    bit    quiet;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 3) ; // repeated time stamp
      else if (r < 6) gen_now += 48'($urandom_range(100001, 32'h01FF_FFFF));
      else if (r < 8) gen_now = {16'($urandom), $urandom};
      else if (r < 9) gen_now = '0;
      else gen_now += 48'($urandom_range(1, max_step));
      quiet = $urandom_range(0, 99) < p_quiet;
      t.now_us = gen_now;
      t.frame_new = $urandom_range(0, 99) < p_frame;
      t.stick_lat = pick_stick(quiet);
      t.stick_fwd = pick_stick(quiet);
      t.stick_yaw = pick_stick(quiet);
      t.key_mask = (!quiet && $urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
      t.switch_pos = pick_switch();
      t.armed = $urandom_range(0, 4) != 0;
      queue_tick(t);
    end
  endtask

  // full yaw at the longest step so the heading is driven through a wrap
  task automatic spin_ticks(int n, bit neg_yaw);
    tick_t t;
    repeat (n) begin
      gen_now += 48'(MAX_DT);
      t.now_us = gen_now;
      t.frame_new = 1'b1;
      t.stick_lat = pick_stick(1'($urandom_range(0, 1)));
      t.stick_fwd = pick_stick(1'($urandom_range(0, 1)));
      t.stick_yaw = neg_yaw ? 12'h800 : 12'h7FF;
      t.key_mask = 4'($urandom);
      t.switch_pos = pick_switch();
      t.armed = 1'($urandom_range(0, 1));
      queue_tick(t);
    end
  endtask

  task automatic wait_drained();
    while (taken_total != queued_total || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_FWD_LIMIT:     lim_fwd = int'(val[LIM_W-1:0]);
      CFG_LAT_LIMIT:     lim_lat = int'(val[LIM_W-1:0]);
      CFG_DEADZONE:      dz_counts = int'(val[DZ_W-1:0]);
      CFG_FRAME_TIMEOUT: frame_to = val[TO_W-1:0];
      CFG_IDLE_TIMEOUT:  idle_to = val[TO_W-1:0];
      CFG_COUNT_PERIOD:  count_per = val[PER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(int lf, int ll, int dz, logic [23:0] fto, logic [23:0] ito,
                              logic [19:0] per);
    write_reg(CFG_FWD_LIMIT, CFG_W'(lf));
    write_reg(CFG_LAT_LIMIT, CFG_W'(ll));
    write_reg(CFG_DEADZONE, CFG_W'(dz));
    write_reg(CFG_FRAME_TIMEOUT, fto);
    write_reg(CFG_IDLE_TIMEOUT, ito);
    write_reg(CFG_COUNT_PERIOD, CFG_W'(per));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: switch edges, band thresholds, timeouts at their bounds, time wrap
    direct_tick(48'd0, 1, 0, 0, 0, 4'h0, SW_HIGH, 0);
    direct_tick(48'd5000, 1, -2048, 2047, 2047, 4'h0, SW_LOW, 0);
    direct_tick(48'd5000, 1, 2047, -2048, -2048, 4'hF, SW_UNKNOWN, 1);
    direct_tick(48'd20000, 1, -281, 281, 280, 4'h0, SW_LOW, 1);
    direct_tick(48'd40000, 1, 280, -280, -281, 4'h0, SW_HIGH, 1);
    direct_tick(48'd240000, 1, 0, 0, 0, 4'h1, SW_LOW, 1);
    direct_tick(48'd300000, 0, 0, 0, 2047, 4'h0, SW_LOW, 0);
    direct_tick(48'd500001, 0, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd550001, 0, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd560000, 0, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd620001, 1, 50, -50, 80, 4'h0, SW_LOW, 0);
    direct_tick(48'd2240001, 1, 50, -50, 80, 4'h0, SW_LOW, 0);
    direct_tick(48'd2240002, 1, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd2250000, 1, 0, 500, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'hFFFF_FFFF_FFFF - 48'd4999, 1, 0, 0, 2047, 4'h0, SW_LOW, 0);
    direct_tick(48'hFFFF_FFFF_FFFF - 48'd999, 1, 0, 0, 2047, 4'h0, SW_LOW, 0);
    direct_tick(48'd3000, 1, -2048, -2048, -2048, 4'hF, 8'hFF, 1);
    direct_tick(48'd203000, 0, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd203001, 0, 0, 0, 0, 4'h0, SW_LOW, 0);
    direct_tick(48'd210000, 1, 300, 0, 0, 4'h0, SW_LOW, 0);
    gen_now = 48'd210000;

    // receiver holds off while the sender keeps offering, then a gapless spin
    send_gaps_on <= 1'b0;
    recv_stalls_on <= 1'b0;
    hold_reqs <= hold_reqs + 1;
    random_ticks(40, 85, 40, 60000);
    spin_ticks(70, 1'b1);
    repeat (200) @(posedge clk);
    send_gaps_on <= 1'b1;
    recv_stalls_on <= 1'b1;
    random_ticks(40, 85, 40, 60000);
    wait_drained();

    // widest limits, no dead zone, zero timeouts and period: drive the counter to saturation
    apply_config(63, 63, 0, 24'd0, 24'd0, 20'd0);
    random_ticks(265, 50, 100, 20000);
    random_ticks(30, 50, 85, 20000);
    wait_drained();

    // zero limits, widest dead zone, longest timeouts and period
    apply_config(0, 0, 1023, 24'hFF_FFFF, 24'hFF_FFFF, 20'hF_FFFF);
    random_ticks(40, 60, 30, 5000000);
    wait_drained();

    apply_config($urandom_range(1, 63), $urandom_range(1, 63), $urandom_range(0, 300),
                 24'($urandom_range(1000, 100000)), 24'($urandom_range(1000, 200000)),
                 20'($urandom_range(1, 30000)));
    random_ticks(30, 80, 50, 30000);
    wait_drained();
    spin_ticks(140, 1'b0);
    random_ticks(30, 75, 50, 30000);
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
